// File: rtl/fla_pkg.sv
// Shared types and constants of the free-list slot allocator.
`default_nettype none
package fla_pkg;

  localparam int unsigned MAX_SLOTS    = 4096;
  localparam int unsigned HEADER_BYTES = 32;
  localparam int unsigned INDEX_BYTES  = 4;

  localparam int unsigned ADDR_W  = $clog2(MAX_SLOTS);
  localparam int unsigned LINK_W  = 13;
  localparam int unsigned CFG_W   = 17;
  localparam int unsigned DIVD_W  = 17;
  localparam int unsigned DIVS_W  = 18;

  // Request kinds
  localparam logic [1:0] REQ_ALLOC = 2'd0;
  localparam logic [1:0] REQ_FREE  = 2'd1;
  localparam logic [1:0] REQ_INIT  = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_ALLOCATED = 3'd0;
  localparam logic [2:0] ST_EMPTY     = 3'd1;
  localparam logic [2:0] ST_FREED     = 3'd2;
  localparam logic [2:0] ST_RANGE     = 3'd3;
  localparam logic [2:0] ST_INIT_OK   = 3'd4;
  localparam logic [2:0] ST_INIT_FAIL = 3'd5;

  // Configuration register indexes
  localparam logic REG_PAGE_BYTES = 1'b0;
  localparam logic REG_SLOT_BYTES = 1'b1;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DIVS_W-1:0] divisor;
  } div_req_t;

endpackage
`default_nettype wire

// File: rtl/free_list_slot_allocator.sv
// Free-list slot allocator: request sequencer around the link table and divider.
// Alloc: table read (S_READ), then offset add and result (S_FIN); straight to S_FIN when empty.
// Free: runs the 17-step shared divider; straight to S_FIN when rejected up front.
// Init: division, then a sweep relinking each table entry; straight to S_FIN for a too-small page.
// One item is worked at a time; a waiting result holds back only the next item's result.
// rst is synchronous: pool uninitialised, config back to 4096 and 24 bytes.
`default_nettype none
module free_list_slot_allocator (
  input  wire logic        clk,
  input  wire logic        rst,
  // tdata: free_offset[15:0]
  input  wire logic [15:0] s_tdata,
  // tuser: req_type[1:0]
  input  wire logic [1:0]  s_tuser,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // tdata: slot_index[11:0], slot_offset[27:12], slot_count[40:28],
  //        next_free[53:41], zero padding
  output logic [55:0]      m_tdata,
  // tuser: status[2:0]
  output logic [2:0]       m_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  input  wire logic        wr_en,
  input  wire logic        wr_index,
  input  wire logic [16:0] wr_data
);
  import fla_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_READ  = 5'b00010,
    S_DIV   = 5'b00100,
    S_SWEEP = 5'b01000,
    S_FIN   = 5'b10000
  } state_t;

  state_t state;

  logic [CFG_W-1:0]  page_bytes;
  logic [CFG_W-1:0]  slot_bytes;
  logic [LINK_W-1:0] free_head;
  logic [LINK_W-1:0] pool_slots;
  logic [CFG_W-1:0]  slots_base;
  logic [CFG_W-1:0]  pool_obj;

  logic [1:0]        op;
  logic [2:0]        stat;
  logic [ADDR_W-1:0] idx;
  logic [LINK_W-1:0] new_head;
  logic [15:0]       prod;
  logic [ADDR_W-1:0] sweep;

  logic              accept;
  logic              out_free;
  logic [15:0]       offset;
  div_req_t          div_req;
  logic              div_done;
  logic [DIVD_W-1:0] div_quot;
  logic [LINK_W-1:0] count;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [LINK_W-1:0] ram_wdata;
  logic [LINK_W-1:0] ram_rdata;

  logic [LINK_W-1:0] head_next;
  logic [LINK_W-1:0] slots_next;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign offset   = s_tdata[15:0];

  // Saturate the slot count
  assign count = (div_quot > DIVD_W'(MAX_SLOTS)) ? LINK_W'(MAX_SLOTS)
                                                 : LINK_W'(div_quot);

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    if (accept && s_tuser == REQ_FREE) begin
      div_req.start    = (pool_slots != '0) && ({1'b0, offset} >= slots_base);
      div_req.dividend = DIVD_W'({1'b0, offset} - slots_base);
      div_req.divisor  = (pool_obj == '0) ? DIVS_W'(1) : {1'b0, pool_obj};
    end else if (accept && s_tuser == REQ_INIT) begin
      div_req.start    = page_bytes > CFG_W'(HEADER_BYTES);
      div_req.dividend = DIVD_W'(page_bytes - CFG_W'(HEADER_BYTES));
      div_req.divisor  = {1'b0, slot_bytes} + DIVS_W'(INDEX_BYTES);
    end
  end

  fla_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .done (div_done),
    .quot (div_quot)
  );

  always_comb begin
    head_next  = free_head;
    slots_next = pool_slots;
    case (stat)
      ST_ALLOCATED: head_next = new_head;
      ST_FREED:     head_next = {1'b0, idx};
      ST_INIT_FAIL: begin
        head_next  = '0;
        slots_next = '0;
      end
      default: ;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = free_head;
    if (state == S_SWEEP) begin
      ram_we    = 1'b1;
      ram_waddr = sweep;
      ram_wdata = LINK_W'(sweep) + LINK_W'(1);
    end else if (state == S_FIN && out_free && stat == ST_FREED) begin
      ram_we = 1'b1;
    end
  end

  fla_ram #(
    .WIDTH (LINK_W),
    .DEPTH (MAX_SLOTS)
  ) u_links (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (free_head[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      m_tvalid   <= 1'b0;
      page_bytes <= CFG_W'(4096);
      slot_bytes <= CFG_W'(24);
      free_head  <= '0;
      pool_slots <= '0;
      slots_base <= '0;
      pool_obj   <= '0;
    end else begin
      if (wr_en) begin
        unique case (wr_index)
          REG_PAGE_BYTES: page_bytes <= wr_data;
          REG_SLOT_BYTES: slot_bytes <= wr_data;
        endcase
      end
      // The finishing state raises valid itself
      if (m_tvalid && m_tready && state != S_FIN) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (s_tuser)
              REQ_ALLOC: state <= (free_head >= pool_slots) ? S_FIN : S_READ;
              REQ_FREE:  state <= div_req.start ? S_DIV : S_FIN;
              REQ_INIT:  state <= div_req.start ? S_DIV : S_FIN;
              default:   state <= S_IDLE;
            endcase
          end
        end
        S_READ: state <= S_FIN;
        S_DIV: begin
          if (div_done) begin
            if (op == REQ_INIT && count != '0) begin
              pool_slots <= count;
              pool_obj   <= slot_bytes;
              slots_base <= CFG_W'(HEADER_BYTES) + CFG_W'(count) * CFG_W'(INDEX_BYTES);
              free_head  <= '0;
              state      <= S_SWEEP;
            end else begin
              state <= S_FIN;
            end
          end
        end
        S_SWEEP: begin
          if ({1'b0, sweep} == pool_slots - LINK_W'(1)) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            m_tvalid   <= 1'b1;
            free_head  <= head_next;
            pool_slots <= slots_next;
            if (stat == ST_INIT_FAIL) begin
              slots_base <= '0;
              pool_obj   <= '0;
            end
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

  // Item context and result payload
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        sweep <= '0;
        if (accept) begin
          op  <= s_tuser;
          idx <= free_head[ADDR_W-1:0];
          case (s_tuser)
            REQ_ALLOC: stat <= (free_head >= pool_slots) ? ST_EMPTY : ST_ALLOCATED;
            REQ_FREE:  stat <= ST_RANGE;
            default:   stat <= ST_INIT_FAIL;
          endcase
        end
      end
      S_READ: begin
        new_head <= ram_rdata;
        prod     <= 16'(idx * pool_obj);
      end
      S_DIV: begin
        if (div_done) begin
          if (op == REQ_FREE) begin
            if (div_quot < DIVD_W'(pool_slots)) begin
              stat <= ST_FREED;
              idx  <= div_quot[ADDR_W-1:0];
            end
          end else if (count != '0) begin
            stat <= ST_INIT_OK;
          end
        end
      end
      S_SWEEP: sweep <= sweep + ADDR_W'(1);
      S_FIN: begin
        if (out_free) begin
          m_tuser         <= stat;
          m_tdata[11:0]   <= (stat == ST_ALLOCATED || stat == ST_FREED) ? idx : '0;
          m_tdata[27:12]  <= (stat == ST_ALLOCATED) ? slots_base[15:0] + prod : '0;
          m_tdata[40:28]  <= slots_next;
          m_tdata[53:41]  <= head_next;
          m_tdata[55:54]  <= '0;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/fla_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module fla_ram #(
  parameter int unsigned WIDTH = 13,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: rtl/fla_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module fla_div (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire fla_pkg::div_req_t        req,
  output logic                          done,
  output logic [fla_pkg::DIVD_W-1:0]    quot
);
  import fla_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIVD_W + 1);

  logic              busy;
  logic [CNT_W-1:0]  steps;
  logic [DIVS_W-1:0] rem;
  logic [DIVS_W-1:0] dsr;
  logic [DIVS_W:0]   trial;
  logic              ge;

  assign trial = {rem, quot[DIVD_W-1]};
  assign ge    = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        steps <= CNT_W'(DIVD_W);
      end else if (busy) begin
        steps <= steps - CNT_W'(1);
        if (steps == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Dividend shifts out at the top while quotient bits enter at the bottom
  always_ff @(posedge clk) begin
    if (req.start) begin
      quot <= req.dividend;
      dsr  <= req.divisor;
      rem  <= '0;
    end else if (busy) begin
      quot <= {quot[DIVD_W-2:0], ge};
      rem  <= ge ? DIVS_W'(trial - {1'b0, dsr}) : DIVS_W'(trial);
    end
  end

endmodule
`default_nettype wire

// File: tb/sv/testbench.sv
// Testbench for the free-list slot allocator: directed and random requests against a predictor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import fla_pkg::*;

  localparam logic [1:0]  REQ_UNUSED    = 2'd3;
  localparam int unsigned RANDOM_ITEMS  = 1450;
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int unsigned CYCLE_LIMIT   = 4000000;
  localparam int unsigned REPORT_LIMIT  = 10;

  typedef struct packed {
    logic [2:0]  status;
    logic [11:0] index;
    logic [15:0] offset;
    logic [12:0] count;
    logic [12:0] next_free;
  } slot_reply_t;

  // Mirrors the pool: link table, free head, geometry latched at init, and pending replies.
  class slot_pool_scoreboard;
    logic [LINK_W-1:0] link_table [MAX_SLOTS];
    int unsigned head, pool_slots, slots_base, pool_obj;
    int unsigned page_bytes, slot_bytes;
    slot_reply_t expected_replies[$];
    logic [15:0] granted_offsets[$];
    int unsigned mismatches, checked;
    int unsigned status_seen[8];

    function new();
      page_bytes = 4096;
      slot_bytes = 24;
      head = 0;
      pool_slots = 0;
      slots_base = 0;
      pool_obj = 0;
      mismatches = 0;
      checked = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void set_register(logic idx, logic [CFG_W-1:0] value);
      if (idx == REG_PAGE_BYTES) page_bytes = 32'(value);
      else slot_bytes = 32'(value);
    endfunction

    function void note_request(logic [1:0] req, logic [15:0] offset);
      slot_reply_t r;
      int unsigned cnt, idx, divisor;
      r = '0;
      case (req)
        REQ_ALLOC: begin
          if (head >= pool_slots || head >= MAX_SLOTS) begin
            r.status = ST_EMPTY;
          end else begin
            r.status = ST_ALLOCATED;
            r.index  = 12'(head);
            r.offset = 16'(slots_base + head * pool_obj);
            head = 32'(link_table[head]);
            granted_offsets.push_back(r.offset);
          end
        end
        REQ_FREE: begin
          divisor = (pool_obj == 0) ? 1 : pool_obj;
          r.status = ST_RANGE;
          if (pool_slots != 0 && offset >= slots_base) begin
            idx = (offset - slots_base) / divisor;
            if (idx < pool_slots && idx < MAX_SLOTS) begin
              link_table[idx] = LINK_W'(head);
              head = idx;
              r.status = ST_FREED;
              r.index  = 12'(idx);
            end
          end
        end
        REQ_INIT: begin
          cnt = 0;
          if (page_bytes > HEADER_BYTES)
            cnt = (page_bytes - HEADER_BYTES) / (slot_bytes + INDEX_BYTES);
          if (cnt > MAX_SLOTS) cnt = MAX_SLOTS;
          granted_offsets.delete();
          head = 0;
          if (cnt == 0) begin
            pool_slots = 0;
            slots_base = 0;
            pool_obj   = 0;
            r.status   = ST_INIT_FAIL;
          end else begin
            pool_slots = cnt;
            pool_obj   = slot_bytes;
            slots_base = HEADER_BYTES + cnt * INDEX_BYTES;
            for (int i = 0; i < cnt; i++) link_table[i] = LINK_W'(i + 1);
            r.status = ST_INIT_OK;
          end
        end
        default: return;
      endcase
      r.count     = 13'(pool_slots);
      r.next_free = 13'(head);
      status_seen[r.status]++;
      expected_replies.push_back(r);
    endfunction

    function void check_reply(slot_reply_t got);
      slot_reply_t want;
      checked++;
      if (expected_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected reply: status %0d index %0d offset %0d count %0d next %0d",
                   got.status, got.index, got.offset, got.count, got.next_free);
        return;
      end
      want = expected_replies.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("reply %0d: expected status %0d index %0d offset %0d count %0d next %0d",
                   checked, want.status, want.index, want.offset, want.count, want.next_free);
          $display("reply %0d:      got status %0d index %0d offset %0d count %0d next %0d",
                   checked, got.status, got.index, got.offset, got.count, got.next_free);
        end
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic [15:0]       s_tdata = '0;
  logic [1:0]        s_tuser = '0;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [55:0]       m_tdata;
  logic [2:0]        m_tuser;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic              wr_en = 1'b0;
  logic              wr_index = 1'b0;
  logic [CFG_W-1:0]  wr_data = '0;

  bit          steady = 1'b0;
  int unsigned cycles = 0;
  int unsigned sent = 0;
  int unsigned ignored = 0;
  int unsigned settings = 0;

  slot_pool_scoreboard sb = new();

  free_list_slot_allocator u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[free_list_slot_allocator] ERROR");
      $finish;
    end
  end

  // Stall the reply side at random, except during the steady stretch.
  always @(negedge clk) begin
    m_tready <= steady || ($urandom_range(0, 99) >= 11);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_reply(slot_reply_t'({m_tuser, m_tdata[11:0], m_tdata[27:12],
                                    m_tdata[40:28], m_tdata[53:41]}));
  end

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_request(input logic [1:0] req, input logic [15:0] offset);
    while (!steady && $urandom_range(0, 99) < 11) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= offset;
    do @(posedge clk); while (!s_tready);
    sb.note_request(req, offset);
    sent++;
    if (req == REQ_UNUSED) ignored++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (sb.expected_replies.size() != 0) @(posedge clk);
    // an ignored code leaves no reply, so give the sequencer time to settle
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] value);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= value;
    sb.set_register(idx, value);
    @(negedge clk);
  endtask

  task automatic configure(input int unsigned page, input int unsigned slot);
    wait_idle();
    write_reg(REG_PAGE_BYTES, CFG_W'(page));
    write_reg(REG_SLOT_BYTES, CFG_W'(slot));
    wr_en <= 1'b0;
    settings++;
  endtask

  initial begin
    int unsigned real_items, phase_len, pick, unit, j, cfg_page, cfg_slot;
    int unsigned extreme_pages[4];
    int unsigned extreme_slots[2];
    logic [1:0]  req;
    logic [15:0] offset;

    extreme_pages = '{1, 32, 33, 65536};
    extreme_slots = '{1, 65536};
    real_items = 0;

    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // Reset geometry: 145 slots of 24 bytes from offset 612.
    send_request(REQ_ALLOC, 16'h0000);     // pool not yet initialised
    send_request(REQ_FREE, 16'h0000);
    send_request(REQ_UNUSED, 16'hFFFF);
    send_request(REQ_INIT, 16'hFFFF);
    send_request(REQ_ALLOC, 16'h0000);
    send_request(REQ_ALLOC, 16'h0000);
    send_request(REQ_FREE, 16'd636);
    send_request(REQ_FREE, 16'd625);       // unaligned, truncates to slot 0
    send_request(REQ_FREE, 16'd611);       // just below the first slot
    send_request(REQ_FREE, 16'hFFFF);
    send_request(REQ_FREE, 16'd4091);      // last slot
    send_request(REQ_ALLOC, 16'h0000);

    // Page no larger than the header: init fails and the pool stays empty.
    configure(32, 24);
    send_request(REQ_INIT, 16'h0000);
    send_request(REQ_ALLOC, 16'h0000);
    send_request(REQ_FREE, 16'h0000);

    // Single slot: drain and return it.
    configure(37, 1);
    send_request(REQ_INIT, 16'h0000);
    send_request(REQ_ALLOC, 16'h0000);
    send_request(REQ_ALLOC, 16'h0000);
    send_request(REQ_FREE, 16'd36);

    // Zero slot size: every offset is the base, free divides by one.
    configure(100, 0);
    send_request(REQ_INIT, 16'h0000);
    send_request(REQ_ALLOC, 16'h0000);
    send_request(REQ_ALLOC, 16'h0000);
    send_request(REQ_FREE, 16'd116);

    // Count capped at the table size.
    configure(65536, 1);
    send_request(REQ_INIT, 16'h0000);
    send_request(REQ_FREE, 16'd20511);

    // Second slot lies past 64 KiB, so its offset wraps.
    configure(131071, 65500);
    send_request(REQ_INIT, 16'h0000);
    send_request(REQ_ALLOC, 16'h0000);
    send_request(REQ_ALLOC, 16'h0000);

    while (real_items < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        cfg_slot = $urandom_range(1, 64);
        cfg_page = HEADER_BYTES + $urandom_range(1, 48) * (cfg_slot + INDEX_BYTES)
                   + $urandom_range(0, cfg_slot + 3);
      end else if (pick < 85) begin
        cfg_page = $urandom_range(1, 65536);
        cfg_slot = $urandom_range(1, 65536);
      end else if (pick < 95) begin
        cfg_page = $urandom_range(4096, 65536);
        cfg_slot = $urandom_range(1, 16);
      end else begin
        cfg_page = extreme_pages[$urandom_range(0, 3)];
        cfg_slot = extreme_slots[$urandom_range(0, 1)];
      end
      configure(cfg_page, cfg_slot);
      send_request(REQ_INIT, 16'($urandom));
      real_items++;

      phase_len = $urandom_range(30, 90);
      for (int n = 0; n < phase_len; n++) begin
        steady = (real_items >= 500 && real_items < 800);
        pick = $urandom_range(0, 99);
        if (pick < 48) req = REQ_ALLOC;
        else if (pick < 92) req = REQ_FREE;
        else if (pick < 96) req = REQ_INIT;
        else req = REQ_UNUSED;
        offset = 16'($urandom);
        if (req == REQ_FREE) begin
          pick = $urandom_range(0, 99);
          unit = (sb.pool_obj == 0) ? 1 : sb.pool_obj;
          if (pick < 55 && sb.granted_offsets.size() != 0) begin
            // hand back a slot that is out on loan
            j = $urandom_range(0, sb.granted_offsets.size() - 1);
            offset = sb.granted_offsets[j];
            sb.granted_offsets.delete(j);
          end else if (pick < 75 && sb.pool_slots != 0) begin
            offset = 16'(sb.slots_base + $urandom_range(0, sb.pool_slots - 1) * sb.pool_obj
                         + ((pick < 65) ? 0 : $urandom_range(0, unit - 1)));
          end else if (pick < 88) begin
            if ($urandom_range(0, 1) == 0)
              offset = 16'(sb.slots_base - 1 - $urandom_range(0, 7));
            else
              offset = 16'(sb.slots_base + sb.pool_slots * unit + $urandom_range(0, 7));
          end
        end
        send_request(req, offset);
        if (req != REQ_UNUSED) real_items++;
      end
    end
    steady = 1'b0;

    wait_idle();
    $display("Sent %0d items (%0d with the unused code) over %0d register settings.",
             sent, ignored, settings + 1);
    $display("Replies %0d: alloc %0d, empty %0d, freed %0d, range %0d, init ok %0d, fail %0d.",
             sb.checked, sb.status_seen[ST_ALLOCATED], sb.status_seen[ST_EMPTY],
             sb.status_seen[ST_FREED], sb.status_seen[ST_RANGE],
             sb.status_seen[ST_INIT_OK], sb.status_seen[ST_INIT_FAIL]);
    if (sb.mismatches == 0 && sb.expected_replies.size() == 0) begin
      $display("[free_list_slot_allocator] OK");
    end else begin
      $display("[free_list_slot_allocator] ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/fla_pkg.sv
rtl/fla_ram.sv
rtl/fla_div.sv
rtl/free_list_slot_allocator.sv
tb/sv/testbench.sv
